// ===== rtl/rounded_rect_icon_pixel_shader_macros.svh =====
// Assertion macros shared by the icon shader RTL
`ifndef ROUNDED_RECT_ICON_PIXEL_SHADER_MACROS_SVH
`define ROUNDED_RECT_ICON_PIXEL_SHADER_MACROS_SVH

// condition must hold at every edge outside reset
`define RRIP_ASSERT_ALW(lbl, ck, rn, cond, msg) \
	lbl: assert property (@(posedge ck) disable iff (!rn) (cond)) else $error(msg);

// same-cycle implication
`define RRIP_ASSERT_IMP(lbl, ck, rn, ante, cons, msg) \
	lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define RRIP_ASSERT_NXT(lbl, ck, rn, ante, cons, msg) \
	lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) else $error(msg);

`endif

// ===== rtl/rrip_pkg.sv =====
// Shared types, geometry and palette of the icon shader
package rrip_pkg;

	// Q0.16 subsample coordinates
	localparam int FRAC = 16;

	// register indexes
	localparam logic REG_SIZE    = 1'b0;
	localparam logic REG_VARIANT = 1'b1;

	localparam int SIZE_MIN = 8;

	// geometry in Q0.16
	localparam logic [15:0] F_LO = 16'd2294;
	localparam logic [15:0] F_HI = 16'd63242;
	localparam logic [15:0] F_R  = 16'd15401;
	localparam logic [15:0] I_LO = 16'd6554;
	localparam logic [15:0] I_HI = 16'd58982;
	localparam logic [15:0] I_R  = 16'd11141;
	localparam logic [15:0] C_LO = 16'd13435;
	localparam logic [15:0] C_HI = 16'd34079;
	localparam logic [15:0] C_W  = 16'd18022;
	localparam logic [15:0] C_R  = 16'd3277;

	// per-axis shape table: frame, inner ring, cell column/row 0, cell column/row 1
	localparam int SH_FRAME = 0;
	localparam int SH_INNER = 1;
	localparam int SH_COL0  = 2;
	localparam int NUM_SH   = 4;
	localparam logic [15:0] SH_LO [NUM_SH] = '{F_LO, I_LO, C_LO, C_HI};
	localparam logic [15:0] SH_HI [NUM_SH] = '{F_HI, I_HI, 16'(C_LO + C_W), 16'(C_HI + C_W)};
	localparam logic [15:0] SH_R  [NUM_SH] = '{F_R, I_R, C_R, C_R};
	localparam logic [28:0] SH_R2 [NUM_SH] = '{29'd237190801, 29'd124121881,
		29'd10738729, 29'd10738729};

	typedef enum logic [2:0] {
		HIT_NONE,
		HIT_PANEL,
		HIT_CELL0,
		HIT_CELL1,
		HIT_CELL2,
		HIT_CELL3,
		HIT_RING
	} hit_t;

	// colors in units of 1/100000, index 0 red, 1 green, 2 blue
	localparam int COLOR_SCALE = 100000;
	typedef logic [16:0] chan_t;
	typedef logic [0:2][16:0] rgb_t;

	localparam rgb_t PANEL_LOCAL  = {17'd9936, 17'd11608, 17'd17152};
	localparam rgb_t PANEL_REMOTE = {17'd11740, 17'd17220, 17'd17530};
	localparam rgb_t ACC_BLUE     = {17'd42000, 17'd55000, 17'd100000};
	localparam rgb_t ACC_GREEN    = {17'd40000, 17'd84000, 17'd52000};
	localparam rgb_t CELL_RGB [4] = '{
		{17'd88200, 17'd34100, 17'd29000},
		{17'd49400, 17'd78800, 17'd41600},
		{17'd35300, 17'd62400, 17'd33300},
		{17'd31000, 17'd49000, 17'd88200}
	};

	function automatic rgb_t hit_color(input hit_t h, input logic variant);
		rgb_t c;
		case (h)
			HIT_PANEL: c = variant ? PANEL_REMOTE : PANEL_LOCAL;
			HIT_CELL0: c = CELL_RGB[0];
			HIT_CELL1: c = CELL_RGB[1];
			HIT_CELL2: c = CELL_RGB[2];
			HIT_CELL3: c = CELL_RGB[3];
			HIT_RING:  c = variant ? ACC_GREEN : ACC_BLUE;
			default:   c = '0;
		endcase
		return c;
	endfunction

endpackage

// ===== rtl/rrip_if.sv =====
// Stream interfaces: pixel coordinate in, RGBA word out
interface rrip_pix_if;
	logic       valid;
	logic       ready;
	logic [9:0] pixel_x;
	logic [9:0] pixel_y;
	modport source (output valid, pixel_x, pixel_y, input ready);
	modport sink (input valid, pixel_x, pixel_y, output ready);
endinterface

interface rrip_rgba_if;
	logic       valid;
	logic       ready;
	logic [7:0] red;
	logic [7:0] green;
	logic [7:0] blue;
	logic [7:0] alpha;
	modport source (output valid, red, green, blue, alpha, input ready);
	modport sink (input valid, red, green, blue, alpha, output ready);
endinterface

// ===== rtl/rrip_coord_div.sv =====
// Subsample coordinate dividers, one lane per column and row offset
module rrip_coord_div import rrip_pkg::*; #(
	parameter int SUPERSAMPLE = 4,
	parameter int MAX_SIZE    = 1024
) (
	input  logic       clk,
	input  logic [4:0] en,
	input  logic [9:0] px,
	input  logic [9:0] py,
	input  logic [$clog2(2*MAX_SIZE*SUPERSAMPLE+1)-1:0] den,
	output logic [15:0] u [2*SUPERSAMPLE]
);

	localparam int LANES = 2 * SUPERSAMPLE;
	localparam int DW    = $clog2(2 * MAX_SIZE * SUPERSAMPLE + 1);
	localparam int K2W   = $clog2(2048 * SUPERSAMPLE);
	localparam int NUMW  = K2W + FRAC + 1;
	localparam int HW    = NUMW - FRAC;
	localparam int CMPW  = (HW > DW) ? HW : DW;
	localparam int NSTG  = 5;
	localparam int STEP  = FRAC / (NSTG - 1);

	for (genvar l = 0; l < LANES; l++) begin : g_lane
		localparam int SUB = l % SUPERSAMPLE;

		logic [9:0]      p;
		logic [NUMW-1:0] num;
		logic            ovf;
		// remainder and combined dividend-low / quotient shift register
		logic [DW-1:0]   rem_s [1:NSTG];
		logic [FRAC-1:0] lq_s  [1:NSTG];
		logic            ovf_s [1:NSTG];
		logic [DW-1:0]   rem_n [2:NSTG];
		logic [FRAC-1:0] lq_n  [2:NSTG];

		assign p = (l < SUPERSAMPLE) ? px : py;

		always_comb begin
			num = (NUMW'(2 * (int'(p) * SUPERSAMPLE + SUB) + 1) << FRAC) + NUMW'(den >> 1);
			ovf = CMPW'(num[NUMW-1:FRAC]) >= CMPW'(den);
		end

		always_comb begin
			logic [DW:0] r2;
			r2 = '0;
			for (int s = 2; s <= NSTG; s++) begin
				rem_n[s] = rem_s[s-1];
				lq_n[s]  = lq_s[s-1];
				for (int j = 0; j < STEP; j++) begin
					r2 = {rem_n[s], lq_n[s][FRAC-1]};
					if (r2 >= {1'b0, den}) begin
						rem_n[s] = DW'(r2 - {1'b0, den});
						lq_n[s]  = {lq_n[s][FRAC-2:0], 1'b1};
					end else begin
						rem_n[s] = DW'(r2);
						lq_n[s]  = {lq_n[s][FRAC-2:0], 1'b0};
					end
				end
			end
		end

		always_ff @(posedge clk) begin
			if (en[0]) begin
				ovf_s[1] <= ovf;
				rem_s[1] <= DW'(num[NUMW-1:FRAC]);
				lq_s[1]  <= num[FRAC-1:0];
			end
			for (int s = 2; s <= NSTG; s++) begin
				if (en[s-1]) begin
					ovf_s[s] <= ovf_s[s-1];
					rem_s[s] <= rem_n[s];
					lq_s[s]  <= lq_n[s];
				end
			end
		end

		// at or beyond the icon edge: saturate, no shape reaches it
		assign u[l] = ovf_s[NSTG] ? '1 : lq_s[NSTG];
	end

endmodule

// ===== rtl/rrip_shape.sv =====
// Per-axis distance squares and per-subsample shape classification
module rrip_shape import rrip_pkg::*; #(
	parameter int SUPERSAMPLE = 4
) (
	input  logic        clk,
	input  logic [1:0]  en,
	input  logic [15:0] u   [2*SUPERSAMPLE],
	output hit_t        cls [SUPERSAMPLE*SUPERSAMPLE]
);

	localparam int LANES = 2 * SUPERSAMPLE;
	localparam int NSUB  = SUPERSAMPLE * SUPERSAMPLE;

	typedef struct packed {
		logic        inr;
		logic [13:0] mag;
	} axis_t;

	function automatic axis_t axis_dist(input logic [15:0] c, input logic [15:0] lo,
		input logic [15:0] hi, input logic [15:0] r);
		axis_t       a;
		logic [15:0] lor;
		logic [15:0] hir;
		lor   = lo + r;
		hir   = hi - r;
		a.inr = (c >= lo) && (c <= hi);
		if (c < lor) begin
			a.mag = 14'(lor - c);
		end else if (c > hir) begin
			a.mag = 14'(c - hir);
		end else begin
			a.mag = '0;
		end
		return a;
	endfunction

	axis_t       ax     [LANES][NUM_SH];
	logic        inr_s6 [LANES][NUM_SH];
	logic [27:0] sq_s6  [LANES][NUM_SH];
	hit_t        cls_n  [NSUB];
	hit_t        cls_s7 [NSUB];

	always_comb begin
		for (int l = 0; l < LANES; l++) begin
			for (int s = 0; s < NUM_SH; s++) begin
				ax[l][s] = axis_dist(u[l], SH_LO[s], SH_HI[s], SH_R[s]);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en[0]) begin
			for (int l = 0; l < LANES; l++) begin
				for (int s = 0; s < NUM_SH; s++) begin
					inr_s6[l][s] <= ax[l][s].inr;
					sq_s6[l][s]  <= 28'(ax[l][s].mag * ax[l][s].mag);
				end
			end
		end
	end

	always_comb begin
		logic frame;
		logic inner;
		logic cell_hit;
		int   xi;
		int   yi;
		int   cs;
		int   rs;
		for (int q = 0; q < NSUB; q++) begin
			xi    = q % SUPERSAMPLE;
			yi    = SUPERSAMPLE + q / SUPERSAMPLE;
			frame = inr_s6[xi][SH_FRAME] && inr_s6[yi][SH_FRAME] &&
				(29'(sq_s6[xi][SH_FRAME]) + 29'(sq_s6[yi][SH_FRAME]) <= SH_R2[SH_FRAME]);
			inner = inr_s6[xi][SH_INNER] && inr_s6[yi][SH_INNER] &&
				(29'(sq_s6[xi][SH_INNER]) + 29'(sq_s6[yi][SH_INNER]) <= SH_R2[SH_INNER]);
			cls_n[q] = frame ? HIT_PANEL : HIT_NONE;
			// cells are disjoint, at most one can hit
			for (int i = 0; i < 4; i++) begin
				cs       = SH_COL0 + (i % 2);
				rs       = SH_COL0 + (i / 2);
				cell_hit = inr_s6[xi][cs] && inr_s6[yi][rs] &&
					(29'(sq_s6[xi][cs]) + 29'(sq_s6[yi][rs]) <= SH_R2[cs]);
				if (cell_hit) begin
					cls_n[q] = hit_t'(3'(int'(HIT_CELL0) + i));
				end
			end
			if (frame && !inner) begin
				cls_n[q] = HIT_RING;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en[1]) begin
			cls_s7 <= cls_n;
		end
	end

	assign cls = cls_s7;

endmodule

// ===== rtl/rrip_resolve.sv =====
// Color accumulation, mean division and alpha for one pixel
module rrip_resolve import rrip_pkg::*; #(
	parameter int SUPERSAMPLE = 4
) (
	input  logic       clk,
	input  logic [4:0] en,
	input  logic       variant,
	input  hit_t       cls [SUPERSAMPLE*SUPERSAMPLE],
	output logic [7:0] red,
	output logic [7:0] green,
	output logic [7:0] blue,
	output logic [7:0] alpha
);

	localparam int SS2  = SUPERSAMPLE * SUPERSAMPLE;
	localparam int ROWW = $clog2(SUPERSAMPLE * COLOR_SCALE + 1);
	localparam int SUMW = $clog2(SS2 * COLOR_SCALE + 1);
	localparam int RCW  = $clog2(SUPERSAMPLE + 1);
	localparam int CW   = $clog2(SS2 + 1);
	localparam int NW   = SUMW + 10;
	localparam int DW2  = $clog2(SS2 * 2 * COLOR_SCALE + 1);
	localparam int QB   = 8;
	localparam int STEP = QB / 2;

	// alpha = round(count * 255 / SS2)
	logic [7:0] alpha_tab [SS2+1];
	for (genvar c = 0; c <= SS2; c++) begin : g_alpha
		localparam int AV = (c * 510 + SS2) / (2 * SS2);
		assign alpha_tab[c] = 8'(AV);
	end

	// S8: per-row sums
	logic [ROWW-1:0] rsum_n  [SUPERSAMPLE][3];
	logic [RCW-1:0]  rcnt_n  [SUPERSAMPLE];
	logic [ROWW-1:0] rsum_s8 [SUPERSAMPLE][3];
	logic [RCW-1:0]  rcnt_s8 [SUPERSAMPLE];

	always_comb begin
		rgb_t col;
		for (int r = 0; r < SUPERSAMPLE; r++) begin
			rcnt_n[r] = '0;
			for (int ch = 0; ch < 3; ch++) begin
				rsum_n[r][ch] = '0;
			end
			for (int x = 0; x < SUPERSAMPLE; x++) begin
				col = hit_color(cls[r*SUPERSAMPLE+x], variant);
				if (cls[r*SUPERSAMPLE+x] != HIT_NONE) begin
					rcnt_n[r] = rcnt_n[r] + RCW'(1);
				end
				for (int ch = 0; ch < 3; ch++) begin
					rsum_n[r][ch] = rsum_n[r][ch] + ROWW'(col[ch]);
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en[0]) begin
			rsum_s8 <= rsum_n;
			rcnt_s8 <= rcnt_n;
		end
	end

	// S9: pixel totals
	logic [SUMW-1:0] sum_n  [3];
	logic [CW-1:0]   cnt_n;
	logic [SUMW-1:0] sum_s9 [3];
	logic [CW-1:0]   cnt_s9;

	always_comb begin
		cnt_n = '0;
		for (int ch = 0; ch < 3; ch++) begin
			sum_n[ch] = '0;
		end
		for (int r = 0; r < SUPERSAMPLE; r++) begin
			cnt_n = cnt_n + CW'(rcnt_s8[r]);
			for (int ch = 0; ch < 3; ch++) begin
				sum_n[ch] = sum_n[ch] + SUMW'(rsum_s8[r][ch]);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en[1]) begin
			sum_s9 <= sum_n;
			cnt_s9 <= cnt_n;
		end
	end

	// S10: dividend sum*510 + den, divisor 2*den, den = count*100000
	logic [NW-1:0]  num_n    [3];
	logic [DW2-1:0] den_n;
	logic [DW2-1:0] rem_s10  [3];
	logic [QB-1:0]  lq_s10   [3];
	logic [DW2-1:0] den_s10;
	logic           zero_s10;
	logic [7:0]     alpha_s10;

	always_comb begin
		den_n = DW2'(cnt_s9) * DW2'(2 * COLOR_SCALE);
		for (int ch = 0; ch < 3; ch++) begin
			num_n[ch] = NW'(sum_s9[ch]) * NW'(510) + NW'(cnt_s9) * NW'(COLOR_SCALE);
		end
	end

	always_ff @(posedge clk) begin
		if (en[2]) begin
			for (int ch = 0; ch < 3; ch++) begin
				// quotient stays below 256, so the high part is already reduced
				rem_s10[ch] <= DW2'(num_n[ch] >> QB);
				lq_s10[ch]  <= num_n[ch][QB-1:0];
			end
			den_s10   <= den_n;
			zero_s10  <= (cnt_s9 == '0);
			alpha_s10 <= alpha_tab[cnt_s9];
		end
	end

	// S11 and S12: four quotient bits per stage
	logic [DW2-1:0] rem_a  [3];
	logic [QB-1:0]  lq_a   [3];
	logic [DW2-1:0] rem_s11 [3];
	logic [QB-1:0]  lq_s11  [3];
	logic [DW2-1:0] den_s11;
	logic           zero_s11;
	logic [7:0]     alpha_s11;
	logic [DW2-1:0] rem_b  [3];
	logic [QB-1:0]  lq_b   [3];

	always_comb begin
		logic [DW2:0] r2;
		r2 = '0;
		for (int ch = 0; ch < 3; ch++) begin
			rem_a[ch] = rem_s10[ch];
			lq_a[ch]  = lq_s10[ch];
			for (int j = 0; j < STEP; j++) begin
				r2 = {rem_a[ch], lq_a[ch][QB-1]};
				if (r2 >= {1'b0, den_s10}) begin
					rem_a[ch] = DW2'(r2 - {1'b0, den_s10});
					lq_a[ch]  = {lq_a[ch][QB-2:0], 1'b1};
				end else begin
					rem_a[ch] = DW2'(r2);
					lq_a[ch]  = {lq_a[ch][QB-2:0], 1'b0};
				end
			end
			rem_b[ch] = rem_s11[ch];
			lq_b[ch]  = lq_s11[ch];
			for (int j = 0; j < STEP; j++) begin
				r2 = {rem_b[ch], lq_b[ch][QB-1]};
				if (r2 >= {1'b0, den_s11}) begin
					rem_b[ch] = DW2'(r2 - {1'b0, den_s11});
					lq_b[ch]  = {lq_b[ch][QB-2:0], 1'b1};
				end else begin
					rem_b[ch] = DW2'(r2);
					lq_b[ch]  = {lq_b[ch][QB-2:0], 1'b0};
				end
			end
		end
	end

	logic [7:0] red_s12;
	logic [7:0] green_s12;
	logic [7:0] blue_s12;
	logic [7:0] alpha_s12;

	always_ff @(posedge clk) begin
		if (en[3]) begin
			rem_s11   <= rem_a;
			lq_s11    <= lq_a;
			den_s11   <= den_s10;
			zero_s11  <= zero_s10;
			alpha_s11 <= alpha_s10;
		end
		if (en[4]) begin
			// nothing covered: all channels zero
			red_s12   <= zero_s11 ? '0 : lq_b[0];
			green_s12 <= zero_s11 ? '0 : lq_b[1];
			blue_s12  <= zero_s11 ? '0 : lq_b[2];
			alpha_s12 <= alpha_s11;
		end
	end

	assign red   = red_s12;
	assign green = green_s12;
	assign blue  = blue_s12;
	assign alpha = alpha_s12;

endmodule

// ===== rtl/rounded_rect_icon_pixel_shader.sv =====
// Top level of the rounded-rectangle icon pixel shader
//
//  channel  dir  word                             handshake
//  pix      in   pixel_x[9:0], pixel_y[9:0]       valid/ready
//  rgba     out  red, green, blue, alpha [7:0]    valid/ready
//  cfg      in   cfg_idx, cfg_wdata[10:0]         cfg_we, no back-pressure
//
//  One word per cycle sustained while rgba is ready; each pixel passes from accept to
//  the output register through the 12-stage pipeline: numerator, four stages
//  of coordinate division, distance squares, classification, row sums, totals,
//  color dividend, two stages of color division.
//  Stalls: each stage holds while its successor is full and stalled, bubbles
//  collapse, so pix stays ready while any stage is empty.
//  Reset clears the valid bits and sets size 32 and variant 0.
`include "rounded_rect_icon_pixel_shader_macros.svh"

module rounded_rect_icon_pixel_shader import rrip_pkg::*; #(
	parameter int MAX_SIZE    = 1024,
	parameter int SUPERSAMPLE = 4
) (
	input  logic        clk,
	input  logic        arst_n,
	rrip_pix_if.sink    pix,
	rrip_rgba_if.source rgba,
	input  logic        cfg_we,
	input  logic        cfg_idx,
	input  logic [10:0] cfg_wdata
);

	localparam int DW         = $clog2(2 * MAX_SIZE * SUPERSAMPLE + 1);
	localparam int NST        = 12;
	localparam int RESET_SIZE = (32 > MAX_SIZE) ? MAX_SIZE : 32;
	localparam int SUBS       = SUPERSAMPLE * SUPERSAMPLE;

	// configuration: divisor 2*size*SS is kept ready, size clamped on write
	logic [DW-1:0] den_q;
	logic          variant_q;
	logic [DW-1:0] den_wr;

	always_comb begin
		int unsigned cs;
		cs = 32'(cfg_wdata);
		if (cs < SIZE_MIN) begin
			cs = SIZE_MIN;
		end else if (cs > MAX_SIZE) begin
			cs = MAX_SIZE;
		end
		den_wr = DW'(cs * 2 * SUPERSAMPLE);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			den_q     <= DW'(RESET_SIZE * 2 * SUPERSAMPLE);
			variant_q <= 1'b0;
		end else if (cfg_we) begin
			case (cfg_idx)
				REG_SIZE:    den_q     <= den_wr;
				REG_VARIANT: variant_q <= cfg_wdata[0];
				default: ;
			endcase
		end
	end

	// pipeline valid bits and per-stage enables
	logic [NST:1] vld_s;
	logic [NST:1] en;

	assign en[NST] = !vld_s[NST] || rgba.ready;
	for (genvar i = 1; i < NST; i++) begin : g_en
		assign en[i] = !vld_s[i] || en[i+1];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else begin
			if (en[1]) begin
				vld_s[1] <= pix.valid;
			end
			for (int i = 2; i <= NST; i++) begin
				if (en[i]) begin
					vld_s[i] <= vld_s[i-1];
				end
			end
		end
	end

	assign pix.ready  = en[1];
	assign rgba.valid = vld_s[NST];

	logic [15:0] u   [2*SUPERSAMPLE];
	hit_t        cls [SUBS];

	rrip_coord_div #(
		.SUPERSAMPLE (SUPERSAMPLE),
		.MAX_SIZE    (MAX_SIZE)
	) u_div (
		.clk (clk),
		.en  (en[5:1]),
		.px  (pix.pixel_x),
		.py  (pix.pixel_y),
		.den (den_q),
		.u   (u)
	);

	rrip_shape #(
		.SUPERSAMPLE (SUPERSAMPLE)
	) u_shape (
		.clk (clk),
		.en  (en[7:6]),
		.u   (u),
		.cls (cls)
	);

	rrip_resolve #(
		.SUPERSAMPLE (SUPERSAMPLE)
	) u_resolve (
		.clk     (clk),
		.en      (en[12:8]),
		.variant (variant_q),
		.cls     (cls),
		.red     (rgba.red),
		.green   (rgba.green),
		.blue    (rgba.blue),
		.alpha   (rgba.alpha)
	);

	`RRIP_ASSERT_ALW(a_den_range, clk, arst_n, (den_q >= DW'(2 * SIZE_MIN * SUPERSAMPLE)) && (den_q <= DW'(2 * MAX_SIZE * SUPERSAMPLE)), "size divisor out of range")
	`RRIP_ASSERT_IMP(a_empty_black, clk, arst_n, rgba.valid && (rgba.alpha == 8'd0), (rgba.red == 8'd0) && (rgba.green == 8'd0) && (rgba.blue == 8'd0), "uncovered pixel has color")
	`RRIP_ASSERT_NXT(a_drain, clk, arst_n, vld_s[NST-1] && en[NST], rgba.valid, "word lost before output")

endmodule

// ===== tb/tb_rounded_rect_icon_pixel_shader.sv =====
// Self-checking testbench for the rounded-rectangle icon pixel shader
module tb_rounded_rect_icon_pixel_shader;
	import rrip_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int MAX_SIZE    = 1024;
	localparam int SUPERSAMPLE = 4;
	// pipeline is 12 deep; drain margin before a register write or the end
	localparam int DRAIN       = 24;
	// cycles with no accepted word before the run is declared hung
	localparam int STALL_LIMIT = 2000;
	localparam int RAND_ITEMS  = 1850;

	typedef struct packed {
		logic [7:0] red;
		logic [7:0] green;
		logic [7:0] blue;
		logic [7:0] alpha;
	} rgba_word_t;

	// directed row: coordinate, and a typed result where it is obvious
	typedef struct {
		logic [9:0] x;
		logic [9:0] y;
		bit         typed;
		rgba_word_t word;
	} pix_row_t;

	typedef struct {
		logic [10:0] size;
		logic        variant;
	} setting_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic cfg_idx = REG_SIZE;
	logic [10:0] cfg_wdata = '0;

	rrip_pix_if  pix();
	rrip_rgba_if rgba();

	rounded_rect_icon_pixel_shader #(
		.MAX_SIZE(MAX_SIZE),
		.SUPERSAMPLE(SUPERSAMPLE)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.pix(pix.sink),
		.rgba(rgba.source),
		.cfg_we(cfg_we),
		.cfg_idx(cfg_idx),
		.cfg_wdata(cfg_wdata)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// testbench copy of the two registers
	logic [10:0] shadow_size = 11'd32;
	logic        shadow_variant = 1'b0;

	// idling switch; cleared for the last phase
	bit idle_on = 1'b1;

	// payload riding with the current word: typed expectation, if any
	bit         cur_typed = 1'b0;
	rgba_word_t cur_word;

	rgba_word_t pending_rgba[$];
	int mismatches = 0;
	int words_in = 0;
	int words_out = 0;
	int quiet_cycles = 0;

	// point test against a rounded rectangle, all in exact integers
	function automatic bit in_rrect(longint u, longint v, longint x0, longint y0,
			longint x1, longint y1, longint r);
		longint cx, cy, dx, dy;
		if (u < x0 || u > x1 || v < y0 || v > y1)
			return 1'b0;
		cx = (u < x0 + r) ? x0 + r : ((u > x1 - r) ? x1 - r : u);
		cy = (v < y0 + r) ? y0 + r : ((v > y1 - r) ? y1 - r : v);
		dx = u - cx;
		dy = v - cy;
		return dx * dx + dy * dy <= r * r;
	endfunction

	// subsample center in Q.16, rounded half up
	function automatic longint sub_center(longint p, longint s, longint n);
		longint k;
		k = p * SUPERSAMPLE + s;
		return ((2 * k + 1) * 65536 + n) / (2 * n);
	endfunction

	// shade one pixel with the given register values
	function automatic rgba_word_t shade_pixel(logic [9:0] px, logic [9:0] py,
			logic [10:0] size_reg, logic variant);
		int panel_k[3] = '{86, 98, 137};
		int blue_k[3]  = '{420, 550, 1000};
		int green_k[3] = '{400, 840, 520};
		int cell_k[4][3] = '{'{882, 341, 290}, '{494, 788, 416},
			'{353, 624, 333}, '{310, 490, 882}};
		longint colors[6][3];
		longint sum[3];
		longint cnt, n, u, v, den, val, cx, cy;
		int acc, mix, hit;
		rgba_word_t w;
		n = (size_reg < SIZE_MIN) ? SIZE_MIN : ((size_reg > MAX_SIZE) ? MAX_SIZE : size_reg);
		n = n * SUPERSAMPLE;
		mix = variant ? 10 : 4;
		for (int c = 0; c < 3; c++) begin
			acc = variant ? green_k[c] : blue_k[c];
			colors[0][c] = panel_k[c] * 100 + (acc - panel_k[c]) * mix;
			for (int i = 0; i < 4; i++)
				colors[1 + i][c] = cell_k[i][c] * 100;
			colors[5][c] = acc * 100;
			sum[c] = 0;
		end
		cnt = 0;
		for (int sy = 0; sy < SUPERSAMPLE; sy++) begin
			for (int sx = 0; sx < SUPERSAMPLE; sx++) begin
				u = sub_center(px, sx, n);
				v = sub_center(py, sy, n);
				hit = -1;
				if (in_rrect(u, v, F_LO, F_LO, F_HI, F_HI, F_R))
					hit = 0;
				for (int i = 0; i < 4; i++) begin
					cx = (i & 1) ? C_HI : C_LO;
					cy = (i & 2) ? C_HI : C_LO;
					if (in_rrect(u, v, cx, cy, cx + C_W, cy + C_W, C_R))
						hit = 1 + i;
				end
				// accent ring: inside the frame, outside the inner edge
				if (in_rrect(u, v, F_LO, F_LO, F_HI, F_HI, F_R) &&
						!in_rrect(u, v, I_LO, I_LO, I_HI, I_HI, I_R))
					hit = 5;
				if (hit >= 0) begin
					cnt++;
					for (int c = 0; c < 3; c++)
						sum[c] += colors[hit][c];
				end
			end
		end
		w = '0;
		if (cnt == 0)
			return w;
		den = cnt * COLOR_SCALE;
		val = (sum[0] * 510 + den) / (2 * den);
		w.red = (val > 255) ? 8'd255 : val[7:0];
		val = (sum[1] * 510 + den) / (2 * den);
		w.green = (val > 255) ? 8'd255 : val[7:0];
		val = (sum[2] * 510 + den) / (2 * den);
		w.blue = (val > 255) ? 8'd255 : val[7:0];
		val = (cnt * 510 + SUPERSAMPLE * SUPERSAMPLE) / (2 * SUPERSAMPLE * SUPERSAMPLE);
		w.alpha = (val > 255) ? 8'd255 : val[7:0];
		return w;
	endfunction

	// --- monitor: expectations on accept, compare on output, watchdog ---
	always @(posedge clk) begin
		rgba_word_t want;
		bit took;
		took = 1'b0;
		if (arst_n && pix.valid && pix.ready) begin
			took = 1'b1;
			words_in++;
			pending_rgba.push_back(cur_typed ? cur_word :
				shade_pixel(pix.pixel_x, pix.pixel_y, shadow_size, shadow_variant));
		end
		if (arst_n && rgba.valid && rgba.ready) begin
			took = 1'b1;
			words_out++;
			if (pending_rgba.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("ERROR: unexpected rgba word %h", {rgba.red, rgba.green,
						rgba.blue, rgba.alpha});
			end else begin
				want = pending_rgba.pop_front();
				if (rgba.red !== want.red || rgba.green !== want.green ||
						rgba.blue !== want.blue || rgba.alpha !== want.alpha) begin
					mismatches++;
					if (mismatches <= 10)
						$display("ERROR: word %0d rgba exp %h %h %h %h got %h %h %h %h",
							words_out, want.red, want.green, want.blue, want.alpha,
							rgba.red, rgba.green, rgba.blue, rgba.alpha);
				end
			end
		end
		quiet_cycles = took ? 0 : quiet_cycles + 1;
		if (arst_n && quiet_cycles >= STALL_LIMIT) begin
			$display("ERROR: no progress for %0d cycles", STALL_LIMIT);
			$display("TEST FAILED");
			$finish;
		end
	end

	// --- sink side: ready drops in random bursts while idling is on ---
	initial begin
		int burst;
		rgba.ready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (idle_on && $urandom_range(0, 9) == 0) begin
				burst = $urandom_range(1, 16);
				rgba.ready <= 1'b0;
				repeat (burst) @(negedge clk);
			end
			rgba.ready <= 1'b1;
		end
	end

	// present one word; entered and left at a falling edge
	task automatic push_pixel(logic [9:0] x, logic [9:0] y, bit typed, rgba_word_t w);
		int gap;
		if (idle_on && $urandom_range(0, 7) == 0) begin
			gap = $urandom_range(1, 16);
			pix.valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		pix.valid <= 1'b1;
		pix.pixel_x <= x;
		pix.pixel_y <= y;
		cur_typed <= typed;
		cur_word <= w;
		do @(posedge clk); while (!pix.ready);
		@(negedge clk);
	endtask

	// let the pipeline empty, then a margin for anything still in flight
	task automatic drain_pipe();
		pix.valid <= 1'b0;
		@(negedge clk);
		while (pending_rgba.size() != 0) @(negedge clk);
		repeat (DRAIN) @(negedge clk);
	endtask

	// one write cycle, then cfg_we low again so back-to-back writes never overlap
	task automatic write_reg(logic idx, logic [10:0] data);
		cfg_we <= 1'b1;
		cfg_idx <= idx;
		cfg_wdata <= data;
		@(negedge clk);
		cfg_we <= 1'b0;
		if (idx == REG_SIZE)
			shadow_size = data;
		else
			shadow_variant = data[0];
		@(negedge clk);
	endtask

	// --- stimulus ---
	initial begin
		pix_row_t rows[$];
		setting_t settings[$];
		rgba_word_t blank;
		int per_phase, lim;
		logic [9:0] x, y;

		blank = '0;
		pix.valid = 1'b0;
		pix.pixel_x = '0;
		pix.pixel_y = '0;
		cur_word = '0;

		// directed rows at the reset setting (32 px, local)
		rows = '{
			'{10'd0,    10'd0,    1'b1, blank},    // corner, all subsamples miss
			'{10'd31,   10'd31,   1'b1, blank},    // far corner misses too
			'{10'd32,   10'd5,    1'b1, blank},    // just beyond the right edge
			'{10'd1023, 10'd1023, 1'b1, blank},    // maximum coordinates
			'{10'd0,    10'd1023, 1'b1, blank},
			'{10'd1023, 10'd0,    1'b1, blank},
			'{10'd16,   10'd16,   1'b0, blank},    // panel between cells
			'{10'd10,   10'd10,   1'b0, blank},    // cell 0
			'{10'd22,   10'd10,   1'b0, blank},    // cell 1
			'{10'd10,   10'd22,   1'b0, blank},    // cell 2
			'{10'd22,   10'd22,   1'b0, blank},    // cell 3
			'{10'd1,    10'd16,   1'b0, blank},    // accent ring, left side
			'{10'd16,   10'd1,    1'b0, blank},    // accent ring, top
			'{10'd30,   10'd16,   1'b0, blank},
			'{10'd16,   10'd30,   1'b0, blank},
			'{10'd1,    10'd1,    1'b0, blank},    // rounded corner, partial cover
			'{10'd2,    10'd2,    1'b0, blank},
			'{10'd3,    10'd3,    1'b0, blank},
			'{10'd7,    10'd7,    1'b0, blank},    // cell corner edge
			'{10'd15,   10'd15,   1'b0, blank}
		};

		// sizes below the floor, at both clamps and beyond, and both variants
		settings = '{
			'{11'd8,    1'b1},
			'{11'd0,    1'b0},
			'{11'd7,    1'b1},
			'{11'd1024, 1'b1},
			'{11'd2047, 1'b0},
			'{11'd100,  1'b1},
			'{11'd1000, 1'b0},
			'{11'd13,   1'b0},
			'{11'd32,   1'b1}
		};
		per_phase = RAND_ITEMS / settings.size();

		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		foreach (rows[i])
			push_pixel(rows[i].x, rows[i].y, rows[i].typed, rows[i].word);
		drain_pipe();

		foreach (settings[p]) begin
			write_reg(REG_SIZE, settings[p].size);
			write_reg(REG_VARIANT, settings[p].variant);
			// last phase runs with both sides streaming
			if (p == settings.size() - 1)
				idle_on = 1'b0;
			lim = (settings[p].size < SIZE_MIN) ? SIZE_MIN :
				((settings[p].size > MAX_SIZE) ? MAX_SIZE : settings[p].size);
			for (int k = 0; k < per_phase; k++) begin
				// mostly pixels inside the icon, some anywhere in the field
				if ($urandom_range(0, 6) == 0) begin
					x = 10'($urandom_range(0, 1023));
					y = 10'($urandom_range(0, 1023));
				end else begin
					x = 10'($urandom_range(0, lim - 1));
					y = 10'($urandom_range(0, lim - 1));
				end
				push_pixel(x, y, 1'b0, blank);
			end
			drain_pipe();
		end

		$display("Covered %0d pixel words in, %0d rgba words out over %0d register settings,",
			words_in, words_out, settings.size() + 1);
		$display("sizes clamped low and high, both accent variants, with and without idling.");
		if (mismatches == 0 && pending_rgba.size() == 0) begin
			$display("TEST PASSED");
		end else begin
			$display("ERROR: %0d mismatches, %0d words never produced", mismatches,
				pending_rgba.size());
			$display("TEST FAILED");
		end
		$finish;
	end

endmodule
